>>> src/cursor_sequence_store_assert.svh
// Assertion macros for the cursor sequence store checker.
// Both expect signals named clock and reset in the scope of use.
`ifndef CURSOR_SEQUENCE_STORE_ASSERT_SVH
`define CURSOR_SEQUENCE_STORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cursor sequence store check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cursor sequence store check failed");

`endif

>>> src/csq_pkg.sv
package csq_pkg;

   localparam int DEPTH_DEFAULT     = 32;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int CMD_BITS          = 3;
   localparam int STATUS_BITS       = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_START   = 3'd0,
      CMD_ADVANCE = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_ATTACH  = 3'd3,
      CMD_REMOVE  = 3'd4,
      CMD_QUERY   = 3'd5
   } command_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_NO_CURRENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE,
      ST_SHRINK,
      ST_READ,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

>>> src/csq_store.sv
module csq_store #(
   parameter int DEPTH     = csq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = csq_pkg::WORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  csq_pkg::mem_ctl_type     mem_ctl,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]     wr_data,
   output logic [WORD_BITS-1:0]     rd_data
);
   import csq_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/csq_alu.sv
module csq_alu #(
   parameter int CNT_BITS = 6
) (
   input  logic [CNT_BITS-1:0] a,
   input  logic [CNT_BITS-1:0] b,
   input  logic                dec,
   output logic [CNT_BITS-1:0] next,
   output logic                lt
);
   import csq_pkg::*;

   // One incrementer or decrementer and one magnitude compare, shared by every step.
   assign next = dec ? (a - CNT_BITS'(1)) : (a + CNT_BITS'(1));
   assign lt   = (a < b);

endmodule

>>> src/csq_seq.sv
module csq_seq #(
   parameter int DEPTH     = csq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = csq_pkg::WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [csq_pkg::CMD_BITS-1:0]  req_command,
   input  logic [WORD_BITS-1:0]          req_value,
   output logic                          req_stall,
   input  logic                          slot_free,
   output logic                          load,
   output logic [WORD_BITS-1:0]          current_value,
   output logic                          has_current,
   output logic [$clog2(DEPTH+1)-1:0]    entry_count,
   output logic [csq_pkg::STATUS_BITS-1:0] status,
   output csq_pkg::mem_ctl_type          mem_ctl,
   output logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [$clog2(DEPTH)-1:0]      wr_addr,
   output logic [WORD_BITS-1:0]          wr_data,
   input  logic [WORD_BITS-1:0]          rd_data
);
   import csq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   state_type            state_ff, state_in;
   status_type           status_ff, status_in;
   logic [WORD_BITS-1:0] value_ff, value_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  cursor_ff, cursor_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  nbr_ff, nbr_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic                 up_ff, up_in;
   logic                 has_ff, has_in;

   logic [CNT_BITS-1:0]  alu_a, alu_b, alu_next;
   logic                 alu_dec, alu_lt;
   command_type          cmd;

   csq_alu #(.CNT_BITS(CNT_BITS)) u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .dec  (alu_dec),
      .next (alu_next),
      .lt   (alu_lt)
   );

   assign cmd       = command_type'(req_command);
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      nbr_ff    <= nbr_in;
      pos_ff    <= pos_in;
      up_ff     <= up_in;
      has_ff    <= has_in;
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      idx_in    = idx_ff;
      nbr_in    = nbr_ff;
      pos_in    = pos_ff;
      up_in     = up_ff;
      has_in    = has_ff;
      alu_a     = cursor_ff;
      alu_b     = count_ff;
      alu_dec   = 1'b0;
      mem_ctl   = '0;
      rd_addr   = cursor_ff[IDX_BITS-1:0];
      wr_addr   = idx_ff[IDX_BITS-1:0];
      wr_data   = rd_data;
      load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Here the unit gives cursor + 1 and whether the cursor is on an entry.
            if (req_valid) begin
               value_in  = req_value;
               status_in = STATUS_DONE;
               state_in  = ST_READ;
               unique case (cmd) inside
                  CMD_START: begin
                     cursor_in = '0;
                  end
                  CMD_ADVANCE: begin
                     if (alu_lt) begin
                        cursor_in = alu_next;
                     end else begin
                        status_in = STATUS_NO_CURRENT;
                     end
                  end
                  CMD_INSERT, CMD_ATTACH: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = STATUS_FULL;
                     end else begin
                        if (cmd == CMD_INSERT) begin
                           pos_in = alu_lt ? cursor_ff : '0;
                        end else begin
                           pos_in = alu_lt ? alu_next : count_ff;
                        end
                        idx_in   = count_ff;
                        up_in    = 1'b1;
                        state_in = ST_LOOP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!alu_lt) begin
                        status_in = STATUS_NO_CURRENT;
                     end else begin
                        // For removal the index walks the source of each move.
                        idx_in   = alu_next;
                        up_in    = 1'b0;
                        state_in = ST_LOOP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOP: begin
            if (up_ff) begin
               alu_a    = pos_ff;
               alu_b    = idx_ff;
               state_in = alu_lt ? ST_SHIFT_RD : ST_WRITE;
            end else begin
               alu_a    = idx_ff;
               alu_b    = count_ff;
               state_in = alu_lt ? ST_SHIFT_RD : ST_SHRINK;
            end
         end
         ST_SHIFT_RD: begin
            alu_a         = idx_ff;
            alu_dec       = 1'b1;
            nbr_in        = alu_next;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = up_ff ? alu_next[IDX_BITS-1:0] : idx_ff[IDX_BITS-1:0];
            state_in      = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            alu_a         = idx_ff;
            mem_ctl.wr_en = 1'b1;
            wr_addr       = up_ff ? idx_ff[IDX_BITS-1:0] : nbr_ff[IDX_BITS-1:0];
            wr_data       = rd_data;
            idx_in        = up_ff ? nbr_ff : alu_next;
            state_in      = ST_LOOP;
         end
         ST_WRITE: begin
            alu_a         = count_ff;
            mem_ctl.wr_en = 1'b1;
            wr_addr       = pos_ff[IDX_BITS-1:0];
            wr_data       = value_ff;
            count_in      = alu_next;
            cursor_in     = pos_ff;
            state_in      = ST_READ;
         end
         ST_SHRINK: begin
            alu_a    = count_ff;
            alu_dec  = 1'b1;
            count_in = alu_next;
            state_in = ST_READ;
         end
         ST_READ: begin
            has_in        = alu_lt;
            mem_ctl.rd_en = alu_lt;
            rd_addr       = cursor_ff[IDX_BITS-1:0];
            state_in      = ST_FETCH;
         end
         ST_FETCH: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign current_value = has_ff ? rd_data : '0;
   assign has_current   = has_ff;
   assign entry_count   = count_ff;
   assign status        = status_ff;

endmodule

>>> src/cursor_sequence_store.sv
// Ordered list of up to DEPTH words with a cursor, held in a single-port-per-cycle
// store and driven by one shared incrementer and comparator under a small sequencer.
// Each request returns one response giving the word at the cursor, whether the
// cursor is on an entry, the entry count and a status. Start, advance, query,
// unused codes and rejected requests pass through the read and fetch states before
// their response is loaded. Insert, attach and remove first run the shift loop,
// which moves each entry at and above the insertion point for insert and attach,
// and each entry after the cursor for remove: every moved entry costs a compare,
// a store read and a store write. A write or shrink step then precedes the read
// and fetch states. The next request is taken once the response has been placed
// in the output register, which holds it until the receiver releases the stall.
// No clearing pass is needed after reset.
module cursor_sequence_store #(
   parameter int DEPTH     = csq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = csq_pkg::WORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [csq_pkg::CMD_BITS-1:0]    req_command,
   input  logic [WORD_BITS-1:0]            req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [WORD_BITS-1:0]            rsp_current_value,
   output logic                            rsp_has_current,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_entry_count,
   output logic [csq_pkg::STATUS_BITS-1:0] rsp_status
);
   import csq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int IDX_BITS = $clog2(DEPTH);

   mem_ctl_type              mem_ctl;
   logic [IDX_BITS-1:0]      rd_addr, wr_addr;
   logic [WORD_BITS-1:0]     wr_data, rd_data;
   logic                     load, slot_free;
   logic [WORD_BITS-1:0]     seq_value;
   logic                     seq_has;
   logic [CNT_BITS-1:0]      seq_count;
   logic [STATUS_BITS-1:0]   seq_status;

   logic                     rsp_valid_ff;
   logic [WORD_BITS-1:0]     rsp_value_ff;
   logic                     rsp_has_ff;
   logic [CNT_BITS-1:0]      rsp_count_ff;
   logic [STATUS_BITS-1:0]   rsp_status_ff;

   csq_seq #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_command   (req_command),
      .req_value     (req_value),
      .req_stall     (req_stall),
      .slot_free     (slot_free),
      .load          (load),
      .current_value (seq_value),
      .has_current   (seq_has),
      .entry_count   (seq_count),
      .status        (seq_status),
      .mem_ctl       (mem_ctl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_data       (rd_data)
   );

   csq_store #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_value_ff  <= seq_value;
         rsp_has_ff    <= seq_has;
         rsp_count_ff  <= seq_count;
         rsp_status_ff <= seq_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_value = rsp_value_ff;
   assign rsp_has_current   = rsp_has_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> src/csq_checker.sv
`include "cursor_sequence_store_assert.svh"

module csq_checker #(
   parameter int DEPTH     = csq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = csq_pkg::WORD_BITS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [WORD_BITS-1:0]            rsp_current_value,
   input logic                            rsp_has_current,
   input logic [$clog2(DEPTH+1)-1:0]      rsp_entry_count,
   input logic [csq_pkg::STATUS_BITS-1:0] rsp_status
);
   import csq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   // A held response keeps its contents until it is taken.
   `CSQ_ASSERT_NEXT(a_held_response, rsp_valid && rsp_stall, rsp_valid &&
      $stable(rsp_current_value) && $stable(rsp_has_current) &&
      $stable(rsp_entry_count) && $stable(rsp_status))

   `CSQ_ASSERT_SAME(a_empty_cursor_zero, rsp_valid && !rsp_has_current,
      rsp_current_value == '0)

   `CSQ_ASSERT_SAME(a_count_in_range, rsp_valid, rsp_entry_count <= FULL_COUNT)

   // A request refused for a full list can only be seen with every slot in use.
   `CSQ_ASSERT_SAME(a_full_means_full, rsp_valid && (rsp_status == STATUS_FULL),
      rsp_entry_count == FULL_COUNT)

   `CSQ_ASSERT_SAME(a_no_current_rejected,
      rsp_valid && (rsp_status == STATUS_NO_CURRENT), !rsp_has_current)

endmodule

bind cursor_sequence_store csq_checker #(
   .DEPTH     (DEPTH),
   .WORD_BITS (WORD_BITS)
) u_checker (.*);

>>> tb/cursor_sequence_store_tb.sv
module cursor_sequence_store_tb;
   import csq_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int WORD_W       = WORD_BITS_DEFAULT;
   localparam int COUNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int RANDOM_ITEMS = 1250;
   localparam int MAX_REPORTS  = 10;
   localparam int SETTLE_WAIT  = 5 + 3 * LIST_DEPTH + 10;
   localparam int CYCLE_LIMIT  = 800000;

   // Codes 6 and 7 have no command of their own and behave as a query.
   localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

   localparam int STYLE_MIXED = 0;
   localparam int STYLE_FILL  = 1;
   localparam int STYLE_DRAIN = 2;
   localparam int STYLE_WALK  = 3;

   typedef struct packed {
      logic [WORD_W-1:0]  current_value;
      logic               has_current;
      logic [COUNT_W-1:0] entry_count;
      status_type         status;
   } list_view_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic [WORD_W-1:0]   word;
      logic                fixed_view;
      list_view_type       view;
   } directed_row_type;

   localparam list_view_type EMPTY_VIEW = '{32'h0, 1'b0, 6'd0, STATUS_DONE};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CMD_BITS-1:0]       req_command = CMD_QUERY;
   logic [WORD_W-1:0]         req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [WORD_W-1:0]         rsp_current_value;
   logic                      rsp_has_current;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic [STATUS_BITS-1:0]    rsp_status;

   // Predictor state: the stored words, their number and the cursor.
   logic [WORD_W-1:0] list_words [LIST_DEPTH];
   int unsigned       list_count = 0;
   int unsigned       list_cursor = 0;

   list_view_type expected_views [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         stall_left = 0;
   int         rsp_hold;
   logic       rsp_quiet = 1'b0;

   // Rows with a fixed view are checked against that view; the rest against the predictor.
   directed_row_type directed_rows [23] = '{
      '{CMD_QUERY,    32'h0,        1'b1, EMPTY_VIEW},
      '{CMD_ADVANCE,  32'h0,        1'b1, '{32'h0, 1'b0, 6'd0, STATUS_NO_CURRENT}},
      '{CMD_REMOVE,   32'hffffffff, 1'b1, '{32'h0, 1'b0, 6'd0, STATUS_NO_CURRENT}},
      '{CMD_START,    32'h0,        1'b1, EMPTY_VIEW},
      '{CMD_INSERT,   32'hffffffff, 1'b1, '{32'hffffffff, 1'b1, 6'd1, STATUS_DONE}},
      '{CMD_ATTACH,   32'h0,        1'b1, '{32'h0, 1'b1, 6'd2, STATUS_DONE}},
      '{CMD_INSERT,   32'h80000001, 1'b0, EMPTY_VIEW},
      '{CMD_START,    32'h0,        1'b0, EMPTY_VIEW},
      '{CMD_ADVANCE,  32'h0,        1'b0, EMPTY_VIEW},
      '{CMD_ADVANCE,  32'h0,        1'b0, EMPTY_VIEW},
      '{CMD_ADVANCE,  32'h0,        1'b0, EMPTY_VIEW},
      '{CMD_ADVANCE,  32'h0,        1'b1, '{32'h0, 1'b0, 6'd3, STATUS_NO_CURRENT}},
      '{CMD_ATTACH,   32'h12345678, 1'b0, EMPTY_VIEW},
      '{CMD_REMOVE,   32'h0,        1'b1, '{32'h0, 1'b0, 6'd3, STATUS_DONE}},
      '{CMD_INSERT,   32'h00000001, 1'b1, '{32'h1, 1'b1, 6'd4, STATUS_DONE}},
      '{CMD_ADVANCE,  32'h0,        1'b0, EMPTY_VIEW},
      '{CMD_REMOVE,   32'h0,        1'b0, EMPTY_VIEW},
      '{CMD_ATTACH,   32'haaaaaaaa, 1'b0, EMPTY_VIEW},
      '{CMD_SPARE_LO, 32'h55555555, 1'b0, EMPTY_VIEW},
      '{CMD_SPARE_HI, 32'hffffffff, 1'b0, EMPTY_VIEW},
      '{CMD_START,    32'hffffffff, 1'b0, EMPTY_VIEW},
      '{CMD_REMOVE,   32'h0,        1'b0, EMPTY_VIEW},
      '{CMD_INSERT,   32'h55555555, 1'b0, EMPTY_VIEW}
   };

   cursor_sequence_store u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_value (rsp_current_value),
      .rsp_has_current   (rsp_has_current),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Applies one command to the predicted list and returns the view after it.
   function automatic list_view_type apply_list_command(input logic [CMD_BITS-1:0] cmd,
                                                        input logic [WORD_W-1:0] word);
      list_view_type view;
      int unsigned i;
      status_type outcome;
      outcome = STATUS_DONE;
      case (cmd)
         CMD_START: begin
            list_cursor = 0;
         end
         CMD_ADVANCE: begin
            if (list_cursor < list_count) list_cursor++;
            else outcome = STATUS_NO_CURRENT;
         end
         CMD_INSERT: begin
            if (list_count >= LIST_DEPTH) begin
               outcome = STATUS_FULL;
            end else begin
               if (list_cursor >= list_count) list_cursor = 0;
               for (i = list_count; i > list_cursor; i--) list_words[i] = list_words[i-1];
               list_words[list_cursor] = word;
               list_count++;
            end
         end
         CMD_ATTACH: begin
            if (list_count >= LIST_DEPTH) begin
               outcome = STATUS_FULL;
            end else begin
               if (list_cursor >= list_count) begin
                  list_cursor = list_count;
               end else begin
                  list_cursor++;
                  for (i = list_count; i > list_cursor; i--) list_words[i] = list_words[i-1];
               end
               list_words[list_cursor] = word;
               list_count++;
            end
         end
         CMD_REMOVE: begin
            if (list_cursor >= list_count) begin
               outcome = STATUS_NO_CURRENT;
            end else begin
               for (i = list_cursor; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         default: ;
      endcase
      view.has_current   = (list_cursor < list_count);
      view.current_value = view.has_current ? list_words[list_cursor] : '0;
      view.entry_count   = list_count[COUNT_W-1:0];
      view.status        = outcome;
      return view;
   endfunction

   // Called at a rising edge; returns at the edge after the gap that follows acceptance.
   task automatic send_request(input logic [CMD_BITS-1:0] cmd, input logic [WORD_W-1:0] word,
                               input logic use_fixed, input list_view_type fixed,
                               input int gap);
      list_view_type predicted;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= word;
      do @(posedge clock); while (req_stall);
      predicted = apply_list_command(cmd, word);
      expected_views.push_back(use_fixed ? fixed : predicted);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_views.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CMD_BITS-1:0] pick_command(input int style);
      int roll;
      logic [CMD_BITS-1:0] grow;
      roll = $urandom_range(0, 99);
      grow = $urandom_range(0, 1) ? CMD_INSERT : CMD_ATTACH;
      case (style)
         STYLE_FILL: begin
            if (roll < 80) return grow;
            if (roll < 90) return CMD_ADVANCE;
            if (roll < 95) return CMD_START;
         end
         STYLE_DRAIN: begin
            if (roll < 60) return CMD_REMOVE;
            if (roll < 80) return CMD_ADVANCE;
            if (roll < 95) return CMD_START;
         end
         STYLE_WALK: begin
            if (roll < 40) return CMD_ADVANCE;
            if (roll < 60) return CMD_START;
            if (roll < 75) return grow;
            if (roll < 90) return CMD_REMOVE;
         end
         default: begin
            if (roll < 40) return grow;
            if (roll < 60) return CMD_REMOVE;
            if (roll < 70) return CMD_START;
            if (roll < 90) return CMD_ADVANCE;
         end
      endcase
      roll = $urandom_range(0, 2);
      return (roll == 0) ? CMD_QUERY : (roll == 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   // Receiver: checks each accepted response and holds stall for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected response: value %h current %b count %0d status %0d",
                        rsp_current_value, rsp_has_current, rsp_entry_count, rsp_status);
            mismatch_count <= mismatch_count + 1;
         end else begin
            if (rsp_current_value !== expected_views[0].current_value ||
                rsp_has_current !== expected_views[0].has_current ||
                rsp_entry_count !== expected_views[0].entry_count ||
                rsp_status !== expected_views[0].status) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("mismatch: expected value %h current %b count %0d status %0d, %s",
                           expected_views[0].current_value, expected_views[0].has_current,
                           expected_views[0].entry_count, expected_views[0].status,
                           $sformatf("got value %h current %b count %0d status %0d",
                                     rsp_current_value, rsp_has_current,
                                     rsp_entry_count, rsp_status));
               mismatch_count <= mismatch_count + 1;
            end
            void'(expected_views.pop_front());
         end
         if ($urandom_range(0, 29) == 0) rsp_quiet <= !rsp_quiet;
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 14);
         stall_left <= rsp_hold;
         rsp_stall  <= (rsp_hold != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   initial begin
      int random_sent;
      int style;
      int run_length;
      logic sender_quiet;
      random_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n])
         send_request(directed_rows[n].command, directed_rows[n].word,
                      directed_rows[n].fixed_view, directed_rows[n].view,
                      $urandom_range(0, 14));
      wait_for_responses();

      // Runs of one flavour each: filling drives the list to full and beyond, draining
      // empties it, and the others wander about with the cursor.
      while (random_sent < RANDOM_ITEMS) begin
         style = $urandom_range(STYLE_MIXED, STYLE_WALK);
         run_length = (style == STYLE_FILL) ? $urandom_range(40, 70) : $urandom_range(10, 50);
         sender_quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) wait_for_responses();
         repeat (run_length) begin
            send_request(pick_command(style), pick_word(), 1'b0, EMPTY_VIEW,
                         sender_quiet ? 0 : $urandom_range(0, 14));
            random_sent++;
         end
      end

      wait_for_responses();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_views.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
